// ----- sv/rspt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspt_pkg - shared types and constants of the recency sorted peer table
// Table size, field widths, the entry layout and the cell control bundle.
// ----------------------------------------------------------------------------
package rspt_pkg;

	localparam int TABLE_DEPTH = 64;

	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int STAMP_W  = 32;
	localparam int IDX_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);

	// Read path: cells are gathered in groups of eight, one registered pick per group.
	localparam int GRP_SIZE  = 8;
	localparam int GRP_SEL_W = $clog2(GRP_SIZE);
	localparam int NGRP      = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
	localparam int HI_W      = IDX_W - GRP_SEL_W;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef struct packed {
		logic [IP_W-1:0]    ip;
		logic [PORT_W-1:0]  port;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic ins;        // an insert is accepted in this cycle
		logic occupied;   // the cell holds a live entry
		logic prev_keep;  // the neighbor toward the head keeps its entry
	} cell_ctl_t;

endpackage

// ----- sv/rspt_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspt_ifs - request and response channels of the peer table
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rspt_req_if;
	logic                         valid;
	logic                         ready;
	logic                         kind;
	logic [rspt_pkg::IP_W-1:0]    node_ip;
	logic [rspt_pkg::PORT_W-1:0]  node_port;
	logic [rspt_pkg::STAMP_W-1:0] node_time;
	logic [rspt_pkg::IDX_W-1:0]   read_index;

	modport source (output valid, kind, node_ip, node_port, node_time, read_index,
		input ready);
	modport sink (input valid, kind, node_ip, node_port, node_time, read_index,
		output ready);
endinterface

interface rspt_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         entry_valid;
	logic [rspt_pkg::IP_W-1:0]    entry_ip;
	logic [rspt_pkg::PORT_W-1:0]  entry_port;
	logic [rspt_pkg::STAMP_W-1:0] entry_time;
	logic [rspt_pkg::COUNT_W-1:0] entry_count;
	logic                         evicted;

	modport source (output valid, entry_valid, entry_ip, entry_port, entry_time,
		entry_count, evicted, input ready);
	modport sink (input valid, entry_valid, entry_ip, entry_port, entry_time,
		entry_count, evicted, output ready);
endinterface

// ----- sv/rspt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspt_cell - one position of the sorted peer chain
// Keeps its entry, takes the new entry, or takes its neighbor's entry.
// ----------------------------------------------------------------------------
module rspt_cell (
	input  logic               clk,
	input  rspt_pkg::cell_ctl_t ctl,
	input  rspt_pkg::entry_t    new_entry,
	input  rspt_pkg::entry_t    prev_entry,
	output rspt_pkg::entry_t    entry_q,
	output logic                keep
);
	import rspt_pkg::*;

	// Equal stamps stay ahead of the new entry.
	assign keep = ctl.occupied && (entry_q.stamp >= new_entry.stamp);

	always_ff @(posedge clk) begin
		if (ctl.ins && !keep) begin
			entry_q <= ctl.prev_keep ? new_entry : prev_entry;
		end
	end

endmodule

// ----- sv/rspt_grp_mux.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rspt_grp_mux - first stage of the read tree
// Registers the entry of one group of cells chosen by the low index bits.
// ----------------------------------------------------------------------------
module rspt_grp_mux (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [rspt_pkg::GRP_SEL_W-1:0]             sel,
	input  rspt_pkg::entry_t [rspt_pkg::GRP_SIZE-1:0]  entries,
	output rspt_pkg::entry_t                           pick_s1
);
	import rspt_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			pick_s1 <= entries[sel];
		end
	end

endmodule

// ----- sv/recency_sorted_peer_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recency_sorted_peer_table_unit - peer table kept sorted newest first
// A chain of cells inserts an entry in its sorted place; reads go
// through a two level registered selection tree.
// ----------------------------------------------------------------------------
// Channel  Dir  Contents
// req      in   kind, node_ip, node_port, node_time, read_index
// rsp      out  entry_valid, entry_ip, entry_port, entry_time, entry_count, evicted
//
// In an insert every cell decides in parallel and the result is registered at
// the accepting edge. A read passes the group registers, then the response
// register, one per tree level; no new item is taken while a read is in flight.
// Reset clears the entry count and the response valid flag; cell contents are
// unknown until written. A held response blocks new items until it is taken.
// ----------------------------------------------------------------------------
module recency_sorted_peer_table_unit (
	input  logic            clk,
	input  logic            arst_n,
	rspt_req_if.sink        req,
	rspt_rsp_if.source      rsp
);
	import rspt_pkg::*;

	logic [CNT_W-1:0]       count_q;
	logic                   busy_q;
	logic [IDX_W-1:0]       idx_s1;
	logic                   rsp_valid_q;
	logic                   rsp_entry_valid_q;
	entry_t                 rsp_entry_q;
	logic [CNT_W-1:0]       rsp_count_q;
	logic                   rsp_evicted_q;

	entry_t                 cell_q [TABLE_DEPTH];
	logic                   keep [TABLE_DEPTH];
	cell_ctl_t              ctl [TABLE_DEPTH];
	entry_t                 new_entry;
	entry_t [GRP_SIZE-1:0]  grp_in [NGRP];
	entry_t                 grp_s1 [NGRP];
	entry_t                 pick;

	logic                   acc;
	logic                   acc_ins;
	logic                   acc_rd;
	logic                   full;
	logic                   out_free;
	logic                   rd_hit;
	logic [CNT_W+IDX_W-1:0] idx_ext;
	logic [CNT_W+IDX_W-1:0] cnt_cmp;
	logic [CNT_W+COUNT_W-1:0] cnt_out;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !busy_q && out_free;
	assign acc       = req.valid && req.ready;
	assign acc_ins   = acc && (req.kind == KIND_INSERT);
	assign acc_rd    = acc && (req.kind == KIND_READ);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));

	assign new_entry.ip    = req.node_ip;
	assign new_entry.port  = req.node_port;
	assign new_entry.stamp = req.node_time;

	// Cell chain: position 0 is the newest entry.
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		assign ctl[i].ins      = acc_ins;
		assign ctl[i].occupied = (count_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign ctl[i].prev_keep = 1'b1;
			rspt_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.new_entry  (new_entry),
				.prev_entry (new_entry),
				.entry_q    (cell_q[i]),
				.keep       (keep[i])
			);
		end else begin : g_body
			assign ctl[i].prev_keep = keep[i-1];
			rspt_cell u_cell (
				.clk        (clk),
				.ctl        (ctl[i]),
				.new_entry  (new_entry),
				.prev_entry (cell_q[i-1]),
				.entry_q    (cell_q[i]),
				.keep       (keep[i])
			);
		end
	end

	// Read tree, first level: one registered pick per group of cells.
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			for (int k = 0; k < GRP_SIZE; k++) begin
				if (g * GRP_SIZE + k < TABLE_DEPTH) begin
					grp_in[g][k] = cell_q[g * GRP_SIZE + k];
				end else begin
					grp_in[g][k] = '0;
				end
			end
		end
	end

	for (genvar g = 0; g < NGRP; g++) begin : g_grp
		rspt_grp_mux u_grp (
			.clk     (clk),
			.en      (acc_rd),
			.sel     (req.read_index[GRP_SEL_W-1:0]),
			.entries (grp_in[g]),
			.pick_s1 (grp_s1[g])
		);
	end

	// Read tree, second level: choose the group by the high index bits.
	always_comb begin
		pick = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (int'(idx_s1[IDX_W-1:GRP_SEL_W]) == g) begin
				pick = grp_s1[g];
			end
		end
	end

	assign idx_ext = (CNT_W+IDX_W)'(idx_s1);
	assign cnt_cmp = (CNT_W+IDX_W)'(count_q);
	assign rd_hit  = (idx_ext < cnt_cmp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc_ins && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (acc_rd) begin
				busy_q <= 1'b1;
			end else if (busy_q && out_free) begin
				busy_q <= 1'b0;
			end
			if (acc_ins || (busy_q && out_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_rd) begin
			idx_s1 <= req.read_index;
		end
		if (acc_ins) begin
			rsp_entry_valid_q <= 1'b0;
			rsp_entry_q       <= '0;
			rsp_evicted_q     <= full;
			rsp_count_q       <= full ? count_q : count_q + CNT_W'(1);
		end else if (busy_q && out_free) begin
			rsp_entry_valid_q <= rd_hit;
			rsp_entry_q       <= rd_hit ? pick : '0;
			rsp_evicted_q     <= 1'b0;
			rsp_count_q       <= count_q;
		end
	end

	assign cnt_out         = (CNT_W+COUNT_W)'(rsp_count_q);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_valid = rsp_entry_valid_q;
	assign rsp.entry_ip    = rsp_entry_q.ip;
	assign rsp.entry_port  = rsp_entry_q.port;
	assign rsp.entry_time  = rsp_entry_q.stamp;
	assign rsp.entry_count = cnt_out[COUNT_W-1:0];
	assign rsp.evicted     = rsp_evicted_q;

	// The count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table size");

	// An accepted insert shows its response in the next cycle.
	a_ins_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ins |=> rsp.valid && !rsp.entry_valid)
		else $error("insert response missing");

	// Eviction is reported only while the table is full.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> full)
		else $error("eviction reported on a table that is not full");

	// The two newest entries stay in order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(2) |-> cell_q[0].stamp >= cell_q[1].stamp)
		else $error("head of table out of order");

	// No item is taken while a read is in flight.
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ready)
		else $error("item accepted during a read");

endmodule
